### sv/rgbl_pkg.sv
`default_nettype none

package rgbl_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;

  // Forward BT.601 matrix, 8-bit integer form: rows Y, Cb, Cr; columns R, G, B, offset
  localparam logic signed [10:0] FWD_Y_R  = 11'sd66;
  localparam logic signed [10:0] FWD_Y_G  = 11'sd129;
  localparam logic signed [10:0] FWD_Y_B  = 11'sd25;
  localparam logic signed [17:0] FWD_Y_K  = 18'sd4096;
  localparam logic signed [10:0] FWD_CB_R = -11'sd38;
  localparam logic signed [10:0] FWD_CB_G = -11'sd74;
  localparam logic signed [10:0] FWD_CB_B = 11'sd112;
  localparam logic signed [17:0] FWD_CB_K = 18'sd32768;
  localparam logic signed [10:0] FWD_CR_R = 11'sd112;
  localparam logic signed [10:0] FWD_CR_G = -11'sd94;
  localparam logic signed [10:0] FWD_CR_B = -11'sd18;
  localparam logic signed [17:0] FWD_CR_K = 18'sd32768;

  // Inverse matrix: rows R, G, B; columns Y, Cb, Cr, offset
  localparam logic signed [10:0] INV_Y    = 11'sd298;
  localparam logic signed [10:0] INV_R_CR = 11'sd409;
  localparam logic signed [19:0] INV_R_K  = -20'sd57068;
  localparam logic signed [10:0] INV_G_CB = -11'sd100;
  localparam logic signed [10:0] INV_G_CR = -11'sd208;
  localparam logic signed [19:0] INV_G_K  = 20'sd34707;
  localparam logic signed [10:0] INV_B_CB = 11'sd516;
  localparam logic signed [19:0] INV_B_K  = -20'sd70870;

  // Luma range compression: 16 + floor((219*y + 127) / 255)
  localparam logic [7:0]  LUMA_MUL   = 8'd219;
  localparam logic [6:0]  LUMA_BIAS  = 7'd127;
  localparam logic [15:0] RECIP_255  = 16'd32897;  // ceil(2^23 / 255), exact below 2^16
  localparam int unsigned RECIP_SH   = 23;
  localparam logic [7:0]  LUMA_FLOOR = 8'd16;

  localparam logic [7:0]  BYTE_MAX   = 8'd255;

endpackage

`default_nettype wire

### sv/rgb_luma_range_compress_top.sv
`default_nettype none

// RGB luma range compressor. Each beat on the in_ side carries one 8-bit RGB pixel; the
// block converts it to BT.601 YCbCr with the 8-bit integer matrix (each row floored by a
// shift of 8), remaps luma from full range to limited range as 16 + round(y*219/255),
// converts back with the inverse integer matrix and clamps each channel to 0..255. Chroma
// passes through untouched. Throughput is one pixel per clock while out_tready is high,
// with no dependence between pixels. An accepted input beat reaches out_tvalid through
// the five register stages: forward matrix, luma scale, divide by 255 (reciprocal
// multiply), inverse matrix, shift and clamp. Each stage holds its beat only while the
// stage after it is full and stalled, so bubbles are squeezed out and in_tready stays
// high while out_tready is low until the pipeline is truly full. No configuration, no
// state kept between pixels.
module rgb_luma_range_compress_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // per-stage ready: take a beat when empty or when the next stage moves
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 0: forward matrix ----------------
  logic [7:0] red_in, green_in, blue_in;
  logic signed [17:0] rs, gs, bs;
  logic signed [17:0] y_sum, cb_sum, cr_sum;

  assign red_in   = in_tdata[7:0];
  assign green_in = in_tdata[15:8];
  assign blue_in  = in_tdata[23:16];
  assign rs = $signed({10'd0, red_in});
  assign gs = $signed({10'd0, green_in});
  assign bs = $signed({10'd0, blue_in});

  // All three sums stay positive and below 2^16 for byte inputs, so the floor shift
  // is a plain part-select; luma lands in 16..235 and needs no 0..255 clamp.
  assign y_sum  = rgbl_pkg::FWD_Y_R * rs + rgbl_pkg::FWD_Y_G * gs
                + rgbl_pkg::FWD_Y_B * bs + rgbl_pkg::FWD_Y_K;
  assign cb_sum = rgbl_pkg::FWD_CB_R * rs + rgbl_pkg::FWD_CB_G * gs
                + rgbl_pkg::FWD_CB_B * bs + rgbl_pkg::FWD_CB_K;
  assign cr_sum = rgbl_pkg::FWD_CR_R * rs + rgbl_pkg::FWD_CR_G * gs
                + rgbl_pkg::FWD_CR_B * bs + rgbl_pkg::FWD_CR_K;

  logic [7:0] s0_y_r, s0_cb_r, s0_cr_r;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_tvalid) begin
      s0_y_r  <= y_sum[15:8];
      s0_cb_r <= cb_sum[15:8];
      s0_cr_r <= cr_sum[15:8];
    end
  end

  // ---------------- stage 1: luma scale ----------------
  // (438*y + 255) / 510 floors the same as (219*y + 127) / 255
  logic [15:0] luma_num;
  assign luma_num = 16'(rgbl_pkg::LUMA_MUL) * 16'(s0_y_r) + 16'(rgbl_pkg::LUMA_BIAS);

  logic [15:0] s1_t_r;
  logic [7:0]  s1_cb_r, s1_cr_r;

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      s1_t_r  <= luma_num;
      s1_cb_r <= s0_cb_r;
      s1_cr_r <= s0_cr_r;
    end
  end

  // ---------------- stage 2: divide by 255 ----------------
  logic [31:0] recip_prod;
  logic [7:0]  luma_lim;
  assign recip_prod = 32'(s1_t_r) * 32'(rgbl_pkg::RECIP_255);
  assign luma_lim   = recip_prod[rgbl_pkg::RECIP_SH +: 8] + rgbl_pkg::LUMA_FLOOR;

  logic [7:0] s2_y_r, s2_cb_r, s2_cr_r;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld_r[1]) begin
      s2_y_r  <= luma_lim;
      s2_cb_r <= s1_cb_r;
      s2_cr_r <= s1_cr_r;
    end
  end

  // ---------------- stage 3: inverse matrix ----------------
  logic signed [19:0] ys, cbs, crs;
  logic signed [19:0] r_sum, g_sum, b_sum;

  assign ys  = $signed({12'd0, s2_y_r});
  assign cbs = $signed({12'd0, s2_cb_r});
  assign crs = $signed({12'd0, s2_cr_r});

  assign r_sum = rgbl_pkg::INV_Y * ys + rgbl_pkg::INV_R_CR * crs + rgbl_pkg::INV_R_K;
  assign g_sum = rgbl_pkg::INV_Y * ys + rgbl_pkg::INV_G_CB * cbs
               + rgbl_pkg::INV_G_CR * crs + rgbl_pkg::INV_G_K;
  assign b_sum = rgbl_pkg::INV_Y * ys + rgbl_pkg::INV_B_CB * cbs + rgbl_pkg::INV_B_K;

  logic signed [19:0] s3_r_r, s3_g_r, s3_b_r;

  always_ff @(posedge clk) begin
    if (rdy[3] && vld_r[2]) begin
      s3_r_r <= r_sum;
      s3_g_r <= g_sum;
      s3_b_r <= b_sum;
    end
  end

  // ---------------- stage 4: floor shift and clamp ----------------
  function automatic logic [7:0] clamp_byte(input logic signed [19:0] sum);
    logic signed [11:0] sh;
    sh = 12'(sum >>> 8);  // arithmetic shift floors toward minus infinity
    if (sh < 0) begin
      return '0;
    end else if (sh > $signed({4'd0, rgbl_pkg::BYTE_MAX})) begin
      return rgbl_pkg::BYTE_MAX;
    end
    return sh[7:0];
  endfunction

  logic [23:0] s4_pix_r;

  always_ff @(posedge clk) begin
    if (rdy[4] && vld_r[3]) begin
      s4_pix_r <= {clamp_byte(s3_b_r), clamp_byte(s3_g_r), clamp_byte(s3_r_r)};
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = s4_pix_r;

  // ---------------- checks ----------------
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat did not reach the first stage");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (s2_y_r >= 8'd16) && (s2_y_r <= 8'd235))
    else $error("compressed luma outside limited range");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (s0_cb_r >= 8'd16) && (s0_cb_r <= 8'd239)
              && (s0_cr_r >= 8'd16) && (s0_cr_r <= 8'd239))
    else $error("chroma outside 16..239");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !rdy[4] |=> vld_r[3] && $stable(s3_r_r) && $stable(s3_b_r))
    else $error("stalled stage lost or changed its beat");

endmodule

`default_nettype wire

### tb/luma_pixel_checker.sv
module luma_pixel_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [rgbl_pkg::PIX_W-1:0] in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [rgbl_pkg::PIX_W-1:0] out_tdata,
  output int                         mismatch_count,
  output int                         pending_count,
  output int                         checked_count
);

  // red sits in the low byte, blue in the high byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  pixel_t remapped_q[$];

  function automatic logic [7:0] sat_byte(input int signed v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Forward BT.601 integer matrix, full-to-limited luma remap, inverse matrix, byte clamp.
  // Arithmetic shifts floor negative sums.
  function automatic pixel_t remap_pixel(input pixel_t src);
    int signed r, g, b, luma, cb, cr;
    pixel_t res;
    r    = src.red;
    g    = src.green;
    b    = src.blue;
    luma = (66 * r + 129 * g + 25 * b + 4096) >>> 8;
    cb   = (-38 * r - 74 * g + 112 * b + 32768) >>> 8;
    cr   = (112 * r - 94 * g - 18 * b + 32768) >>> 8;
    luma = sat_byte(luma);
    luma = 16 + (438 * luma + 255) / 510;
    res.red   = sat_byte((298 * luma + 409 * cr - 57068) >>> 8);
    res.green = sat_byte((298 * luma - 100 * cb - 208 * cr + 34707) >>> 8);
    res.blue  = sat_byte((298 * luma + 516 * cb - 70870) >>> 8);
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want, got;
    if (!rst_n) begin
      remapped_q.delete();
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
    end else begin
      if (in_tvalid && in_tready) remapped_q.push_back(remap_pixel(pixel_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = pixel_t'(out_tdata);
        if (remapped_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected output beat r=%0d g=%0d b=%0d",
                     got.red, got.green, got.blue);
        end else begin
          want = remapped_q.pop_front();
          checked_count++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch on result %0d: expected r=%0d g=%0d b=%0d, %s",
                       checked_count, want.red, want.green, want.blue,
                       $sformatf("got r=%0d g=%0d b=%0d", got.red, got.green, got.blue));
          end
        end
      end
      pending_count = remapped_q.size();
    end
  end

endmodule

### tb/tb_rgb_luma_range_compress_top.sv
module tb_rgb_luma_range_compress_top;

  localparam int RANDOM_PIXELS = 750;
  // the final stretch of random beats runs with both sides at full rate
  localparam int CALM_TAIL     = 150;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [rgbl_pkg::PIX_W-1:0] in_tdata;   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  logic                       out_tvalid;
  logic                       out_tready;
  logic [rgbl_pkg::PIX_W-1:0] out_tdata;  // [7:0] red_out, [15:8] green_out, [23:16] blue_out

  int   mismatch_count;
  int   pending_count;
  int   checked_count;
  int   directed_sent;
  int   random_sent;
  bit   calm;

  rgb_luma_range_compress_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  luma_pixel_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop: far beyond the slowest legal run (every beat waiting out the
  // longest sender gap and the longest receiver stall).
  initial begin
    #800000;
    $display("FAILED: results differ");
    $finish;
  end

  // Drive one pixel beat: maybe insert an idle burst first, then hold
  // tvalid and tdata until the block takes the beat.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: mix runs of ready with random stall bursts;
  // stay ready once the calm tail begins.
  initial begin : ready_gen
    int hold;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 6);
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 16);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    int guard;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    rst_n         = 1'b0;
    calm          = 1'b0;
    directed_sent = 0;
    random_sent   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: black and white, pure primaries and secondaries
    // (chroma at its extremes), mid and near-extreme grays, and pixels whose
    // inverse sums go negative or overflow and so hit the output clamp.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd0,   8'd128);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd0);
    send_pixel(8'd170, 8'd85,  8'd170);
    send_pixel(8'd85,  8'd170, 8'd85);
    send_pixel(8'd16,  8'd235, 8'd16);
    directed_sent = 18;

    // Random pixels, full byte range on every channel.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS - CALM_TAIL) calm = 1'b1;
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      random_sent++;
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted pixel, then keep clocking with the
    // input idle to expose any stray beat.
    guard = 0;
    while (pending_count != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);

    $display("Sent %0d corner pixels and %0d random pixels under random gaps and stalls",
             directed_sent, random_sent);
    $display("Compared %0d output pixels, %0d mismatches, %0d still outstanding",
             checked_count, mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
